// File: sv/mlfq_round_robin_task_picker_defines.svh
// ----------------------------------------------------------------------------
// MLFQ task picker assertion macros
// Shared assertion forms for the task picker checker.
// ----------------------------------------------------------------------------
`ifndef MLFQ_ROUND_ROBIN_TASK_PICKER_DEFINES_SVH
`define MLFQ_ROUND_ROBIN_TASK_PICKER_DEFINES_SVH

// same-cycle implication
`define MLFQ_AST_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLFQ_AST_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// MLFQ task picker package
// Table sizes, status and result codes, entry type and unit opcodes.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int NUM_TASKS = 64;
  localparam int IDX_W     = $clog2(NUM_TASKS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int OUT_IDX_W = 6;

  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_DYING    = 3'd1;
  localparam logic [2:0] ST_RUNNABLE = 3'd2;
  localparam logic [2:0] ST_RUNNING  = 3'd3;

  localparam logic [1:0] OC_RUN    = 2'd0;
  localparam logic [1:0] OC_IDLE   = 2'd1;
  localparam logic [1:0] OC_NOLIVE = 2'd2;

  localparam logic [1:0] CFG_MODE      = 2'd0;
  localparam logic [1:0] CFG_QUANTUM   = 2'd1;
  localparam logic [1:0] CFG_AGING     = 2'd2;
  localparam logic [1:0] CFG_PRIO_CEIL = 2'd3;

  localparam logic [15:0] QUANTUM_RST   = 16'd5;
  localparam logic [15:0] AGING_RST     = 16'd50;
  localparam logic [7:0]  PRIO_CEIL_RST = 8'd7;
  localparam logic [15:0] RUNS_MAX      = 16'hFFFF;

  localparam logic [2:0] OP_TOP   = 3'd0;
  localparam logic [2:0] OP_AGE   = 3'd1;
  localparam logic [2:0] OP_PICK  = 3'd2;
  localparam logic [2:0] OP_KEEP  = 3'd3;
  localparam logic [2:0] OP_YIELD = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  prio;
    logic [15:0] runs;
  } entry_t;

  typedef struct packed {
    logic   runnable;
    logic   live;
    logic   hit;
    logic   upd;
    entry_t ent;
  } alu_res_t;

endpackage

// File: sv/mlfq_tbl.sv
// ----------------------------------------------------------------------------
// MLFQ task table
// Single write, single registered read; per-entry valid bits give zero reset.
// ----------------------------------------------------------------------------
module mlfq_tbl
  import mlfq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [IDX_W-1:0] wa,
  input  entry_t           wd,
  input  logic [IDX_W-1:0] ra,
  output entry_t           rd
);

  entry_t               mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] vld_r;
  entry_t               q_r;
  logic                 qv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    q_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      qv_r <= vld_r[ra];
      if (we) begin
        vld_r[wa] <= 1'b1;
      end
    end
  end

  // never-written entries read as free, priority 0, no runs
  assign rd = qv_r ? q_r : '0;

endmodule

// File: sv/mlfq_alu.sv
// ----------------------------------------------------------------------------
// MLFQ entry unit
// Shared compare/update unit applied to one table entry per cycle.
// ----------------------------------------------------------------------------
module mlfq_alu
  import mlfq_pkg::*;
(
  input  logic [2:0]  op,
  input  entry_t      ent,
  input  logic        mode,
  input  logic [7:0]  top,
  input  logic [7:0]  prio_ceil,
  input  logic [15:0] quantum,
  output alu_res_t    res
);

  logic [15:0] runs_inc;
  logic        demote;

  always_comb begin
    runs_inc = (ent.runs == RUNS_MAX) ? ent.runs : ent.runs + 16'd1;
    demote   = mode && (ent.runs >= quantum) && (top > 8'd1);

    res.runnable = (ent.status == ST_RUNNABLE);
    res.live     = (ent.status == ST_RUNNABLE) || (ent.status == ST_RUNNING) ||
                   (ent.status == ST_DYING);
    res.hit      = 1'b0;
    res.upd      = 1'b0;
    res.ent      = ent;

    unique case (op)
      OP_TOP: begin
        res.ent = ent;
      end
      OP_AGE: begin
        res.upd      = (ent.status != ST_FREE) && (ent.prio < prio_ceil);
        res.ent.prio = ent.prio + 8'd1;
      end
      OP_PICK: begin
        res.hit        = res.runnable && (!mode || (ent.prio == top));
        res.ent.status = ST_RUNNING;
        res.ent.prio   = demote ? top - 8'd1 : ent.prio;
        res.ent.runs   = runs_inc;
      end
      OP_KEEP: begin
        res.ent.status = ST_RUNNING;
        res.ent.runs   = runs_inc;
      end
      OP_YIELD: begin
        res.ent.status = ST_RUNNABLE;
      end
      default: begin
        res.ent = ent;
      end
    endcase
  end

endmodule

// File: sv/mlfq_round_robin_task_picker.sv
// ----------------------------------------------------------------------------
// MLFQ round-robin task picker
// Task table with round-robin or priority/aging/demotion selection.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | in        | in_valid / in_ready  | func, entry_index, new_status, new_priority
//  out     | out       | out_valid/ out_ready | outcome, chosen_index
//  cfg     | in        | cfg_valid/ cfg_ready | cfg_index (register), cfg_data
//
// A write request is written to the table on acceptance and gives no result.
// A schedule request walks the table through one read port, one entry a cycle:
// round robin is one pass, priority mode a top-priority pass, an optional
// aging pass and, when a task is runnable, a pick pass.
// in_ready is low from a schedule request until its result is taken.
// Reset (rst_n low, synchronous) empties the table at once via valid bits.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module mlfq_round_robin_task_picker
  import mlfq_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_func,
  input  logic [5:0]     in_entry_index,
  input  logic [2:0]     in_new_status,
  input  logic [7:0]     in_new_priority,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_outcome,
  output logic [5:0]     out_chosen_index,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_TOP     = 3'd1;
  localparam logic [2:0] S_AGE     = 3'd2;
  localparam logic [2:0] S_PICK    = 3'd3;
  localparam logic [2:0] S_CUR_RD  = 3'd4;
  localparam logic [2:0] S_CUR_EV  = 3'd5;
  localparam logic [2:0] S_PICK_WR = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  // configuration
  logic        mode_r;
  logic [15:0] quantum_r;
  logic [15:0] aging_int_r;
  logic [7:0]  prio_ceil_r;

  // sequencer state
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             tag_vld_r, tag_vld_nxt;
  logic             tag_last_r, tag_last_nxt;
  logic [IDX_W-1:0] tag_idx_r, tag_idx_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [7:0]       top_r, top_nxt;
  logic             top_vld_r, top_vld_nxt;
  logic             live_r, live_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  entry_t           pick_ent_r, pick_ent_nxt;
  logic             cur_vld_r, cur_vld_nxt;
  logic [IDX_W-1:0] cur_idx_r, cur_idx_nxt;
  logic [15:0]      aging_r, aging_nxt;
  logic [1:0]       outc_r, outc_nxt;
  logic [5:0]       oidx_r, oidx_nxt;

  // datapath
  logic             in_acc;
  logic             scanning, issue, leave;
  logic [CNT_W-1:0] circ_sum;
  logic [IDX_W-1:0] scan_addr, rd_addr;
  logic [2:0]       op;
  logic             cur_run;
  logic [15:0]      age_inc;
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd, rd;
  alu_res_t         alu;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);
  assign out_outcome      = outc_r;
  assign out_chosen_index = oidx_r;

  // register writes, expected only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      quantum_r   <= QUANTUM_RST;
      aging_int_r <= AGING_RST;
      prio_ceil_r <= PRIO_CEIL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:      mode_r      <= cfg_data[0];
        CFG_QUANTUM:   quantum_r   <= cfg_data;
        CFG_AGING:     aging_int_r <= cfg_data;
        CFG_PRIO_CEIL: prio_ceil_r <= cfg_data[7:0];
        default:       mode_r      <= mode_r;
      endcase
    end
  end

  // scan address: plain order for top/aging, circular from start for picking
  assign scanning = (state_r == S_TOP) || (state_r == S_AGE) || (state_r == S_PICK);
  always_comb begin
    circ_sum = {1'b0, start_r} + {1'b0, cnt_r[IDX_W-1:0]};
    if (circ_sum >= CNT_W'(NUM_TASKS)) begin
      circ_sum = circ_sum - CNT_W'(NUM_TASKS);
    end
    scan_addr = (state_r == S_PICK) ? circ_sum[IDX_W-1:0] : cnt_r[IDX_W-1:0];
    rd_addr   = (state_r == S_CUR_RD) ? cur_idx_r : scan_addr;
  end

  always_comb begin
    unique case (state_r)
      S_AGE:    op = OP_AGE;
      S_PICK:   op = OP_PICK;
      S_CUR_EV: op = (found_r && cur_run) ? OP_YIELD : OP_KEEP;
      default:  op = OP_TOP;
    endcase
  end

  mlfq_alu u_alu (
    .op        (op),
    .ent       (rd),
    .mode      (mode_r),
    .top       (top_r),
    .prio_ceil (prio_ceil_r),
    .quantum   (quantum_r),
    .res       (alu)
  );

  mlfq_tbl u_tbl (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we),
    .wa    (wa),
    .wd    (wd),
    .ra    (rd_addr),
    .rd    (rd)
  );

  assign cur_run = cur_vld_r && (rd.status == ST_RUNNING);
  assign age_inc = aging_r + 16'd1;

  always_comb begin
    leave = 1'b0;
    if (tag_vld_r) begin
      if (state_r == S_PICK) begin
        leave = alu.hit || tag_last_r;
      end else if (scanning) begin
        leave = tag_last_r;
      end
    end
    issue = scanning && (cnt_r < CNT_W'(NUM_TASKS)) && !leave;
  end

  // table write port
  always_comb begin
    we = 1'b0;
    wa = pick_r;
    wd = pick_ent_r;
    unique case (state_r)
      S_IDLE: begin
        we = in_acc && !in_func && (CNT_W'(in_entry_index) < CNT_W'(NUM_TASKS));
        wa = IDX_W'(in_entry_index);
        wd = '{status: in_new_status, prio: in_new_priority, runs: 16'd0};
      end
      S_AGE: begin
        we = tag_vld_r && alu.upd;
        wa = tag_idx_r;
        wd = alu.ent;
      end
      S_CUR_EV: begin
        we = cur_run;
        wa = cur_idx_r;
        wd = alu.ent;
      end
      S_PICK_WR: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = leave ? '0 : (issue ? cnt_r + CNT_W'(1) : cnt_r);
    tag_vld_nxt  = issue;
    tag_last_nxt = (cnt_r == CNT_W'(NUM_TASKS - 1));
    tag_idx_nxt  = scan_addr;
    start_nxt    = start_r;
    top_nxt      = top_r;
    top_vld_nxt  = top_vld_r;
    live_nxt     = live_r;
    found_nxt    = found_r;
    pick_nxt     = pick_r;
    pick_ent_nxt = pick_ent_r;
    cur_vld_nxt  = cur_vld_r;
    cur_idx_nxt  = cur_idx_r;
    aging_nxt    = aging_r;
    outc_nxt     = outc_r;
    oidx_nxt     = oidx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_func) begin
          if (cur_vld_r) begin
            start_nxt = (cur_idx_r == IDX_W'(NUM_TASKS - 1)) ? '0 : cur_idx_r + IDX_W'(1);
          end else begin
            start_nxt = '0;
          end
          top_vld_nxt = 1'b0;
          top_nxt     = '0;
          live_nxt    = 1'b0;
          found_nxt   = 1'b0;
          state_nxt   = mode_r ? S_TOP : S_PICK;
        end
      end
      S_TOP: begin
        if (tag_vld_r) begin
          live_nxt = live_r || alu.live;
          if (alu.runnable && (!top_vld_r || (rd.prio > top_r))) begin
            top_nxt     = rd.prio;
            top_vld_nxt = 1'b1;
          end
        end
        if (leave) begin
          // aging counts after the top priority is known
          if (age_inc >= aging_int_r) begin
            aging_nxt = '0;
            state_nxt = S_AGE;
          end else begin
            aging_nxt = age_inc;
            state_nxt = top_vld_nxt ? S_PICK : S_CUR_RD;
          end
        end
      end
      S_AGE: begin
        if (leave) begin
          state_nxt = top_vld_r ? S_PICK : S_CUR_RD;
        end
      end
      S_PICK: begin
        if (tag_vld_r) begin
          live_nxt = live_r || alu.live;
          if (alu.hit) begin
            found_nxt    = 1'b1;
            pick_nxt     = tag_idx_r;
            pick_ent_nxt = alu.ent;
          end
        end
        if (leave) begin
          state_nxt = S_CUR_RD;
        end
      end
      S_CUR_RD: begin
        state_nxt = S_CUR_EV;
      end
      S_CUR_EV: begin
        if (found_r) begin
          state_nxt = S_PICK_WR;
        end else if (cur_run) begin
          // nothing else ready: the running task keeps the CPU
          outc_nxt  = OC_RUN;
          oidx_nxt  = OUT_IDX_W'(cur_idx_r);
          state_nxt = S_OUT;
        end else begin
          outc_nxt = live_r ? OC_IDLE : OC_NOLIVE;
          oidx_nxt = '0;
          if (live_r) begin
            cur_vld_nxt = 1'b0;
          end
          state_nxt = S_OUT;
        end
      end
      S_PICK_WR: begin
        cur_vld_nxt = 1'b1;
        cur_idx_nxt = pick_r;
        outc_nxt    = OC_RUN;
        oidx_nxt    = OUT_IDX_W'(pick_r);
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      tag_vld_r <= 1'b0;
      cur_vld_r <= 1'b0;
      cur_idx_r <= '0;
      aging_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      tag_vld_r <= tag_vld_nxt;
      cur_vld_r <= cur_vld_nxt;
      cur_idx_r <= cur_idx_nxt;
      aging_r   <= aging_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_last_r <= tag_last_nxt;
    tag_idx_r  <= tag_idx_nxt;
    start_r    <= start_nxt;
    top_r      <= top_nxt;
    top_vld_r  <= top_vld_nxt;
    live_r     <= live_nxt;
    found_r    <= found_nxt;
    pick_r     <= pick_nxt;
    pick_ent_r <= pick_ent_nxt;
    outc_r     <= outc_nxt;
    oidx_r     <= oidx_nxt;
  end

endmodule

// File: sv/mlfq_chk.sv
// ----------------------------------------------------------------------------
// MLFQ task picker checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "mlfq_round_robin_task_picker_defines.svh"

module mlfq_chk
  import mlfq_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_outcome,
  input logic [5:0] out_chosen_index
);

  `MLFQ_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `MLFQ_AST_NOW(a_busy_out, out_valid, !in_ready, "request taken with result pending")
  `MLFQ_AST_NXT(a_sched_busy, in_valid && in_ready && in_func, !in_ready, "schedule not busy")
  `MLFQ_AST_NOW(a_outc_code, out_valid, out_outcome <= OC_NOLIVE, "bad outcome")
  `MLFQ_AST_NOW(a_idx_zero, out_valid && out_outcome != OC_RUN, out_chosen_index == 6'd0, "index not zero")

endmodule

bind mlfq_round_robin_task_picker mlfq_chk u_chk (.*);

// File: tb/mlfq_round_robin_task_picker_tb.sv
// ----------------------------------------------------------------------------
// MLFQ task picker testbench
// Drives table writes and schedule requests with random idling and checks
// every outcome against a behavioural model of the task table.
// ----------------------------------------------------------------------------
module mlfq_round_robin_task_picker_tb;
  import mlfq_pkg::*;

  localparam int IDLE_PCT    = 17;
  localparam int WATCHDOG    = 20000;
  localparam int RANDOM_REQS = 1600;

  typedef enum logic { FN_WRITE = 1'b0, FN_SCHED = 1'b1 } func_e;
  typedef logic bool_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [5:0] chosen;
  } sched_res_t;

  // directed rows: check_now means the expected outcome is typed in
  typedef struct {
    func_e      fn;
    logic [5:0] idx;
    logic [2:0] st;
    logic [7:0] pr;
    logic       check_now;
    sched_res_t want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [5:0]  in_entry_index;
  logic [2:0]  in_new_status;
  logic [7:0]  in_new_priority;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_outcome;
  logic [5:0]  out_chosen_index;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  mlfq_round_robin_task_picker dut (.*);

  // model copy of table, current task and registers
  logic [2:0]  tbl_status [NUM_TASKS];
  logic [7:0]  tbl_prio   [NUM_TASKS];
  logic [15:0] tbl_runs   [NUM_TASKS];
  logic        cur_valid;
  logic [5:0]  cur_idx;
  logic [15:0] age_cnt;
  logic        reg_mode;
  logic [15:0] reg_quantum;
  logic [15:0] reg_aging;
  logic [7:0]  reg_prio_ceil;

  sched_res_t pending_results[$];
  int         mismatches;
  int         idle_cycles;
  bool_t      no_idle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: cycles with no request, result or register write accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void model_dispatch(input logic [5:0] p);
    if (cur_valid && tbl_status[cur_idx] == ST_RUNNING) tbl_status[cur_idx] = ST_RUNNABLE;
    tbl_status[p] = ST_RUNNING;
    if (tbl_runs[p] != RUNS_MAX) tbl_runs[p] = tbl_runs[p] + 16'd1;
    cur_valid = 1'b1;
    cur_idx   = p;
  endfunction

  // schedule request: returns outcome and chosen entry
  function automatic sched_res_t model_schedule();
    sched_res_t r;
    logic [5:0] start, idx, p;
    int         top;
    logic       found, live;
    r = '0; found = 1'b0; live = 1'b0; top = -1; p = '0;
    start = cur_valid ? cur_idx + 6'd1 : 6'd0;
    if (!reg_mode) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        idx = start + 6'(i);
        if (!found && tbl_status[idx] == ST_RUNNABLE) begin
          found = 1'b1; p = idx;
        end
      end
    end else begin
      for (int i = 0; i < NUM_TASKS; i++)
        if (tbl_status[i] == ST_RUNNABLE && int'(tbl_prio[i]) > top) top = tbl_prio[i];
      age_cnt = age_cnt + 16'd1;
      if (age_cnt >= reg_aging) begin
        for (int i = 0; i < NUM_TASKS; i++)
          if (tbl_status[i] != ST_FREE && tbl_prio[i] < reg_prio_ceil)
            tbl_prio[i] = tbl_prio[i] + 8'd1;
        age_cnt = '0;
      end
      if (top >= 0)
        for (int i = 0; i < NUM_TASKS; i++) begin
          idx = start + 6'(i);
          if (!found && tbl_status[idx] == ST_RUNNABLE && int'(tbl_prio[idx]) == top) begin
            // demote once the quantum is used up
            if (tbl_runs[idx] >= reg_quantum && top > 1) tbl_prio[idx] = 8'(top - 1);
            found = 1'b1; p = idx;
          end
        end
    end
    if (found) begin
      model_dispatch(p);
      r.outcome = OC_RUN; r.chosen = p;
      return r;
    end
    if (cur_valid && tbl_status[cur_idx] == ST_RUNNING) begin
      p = cur_idx;
      model_dispatch(p);
      r.outcome = OC_RUN; r.chosen = p;
      return r;
    end
    for (int i = 0; i < NUM_TASKS; i++)
      if (tbl_status[i] inside {ST_RUNNABLE, ST_RUNNING, ST_DYING}) live = 1'b1;
    if (!live) r.outcome = OC_NOLIVE;
    else begin
      cur_valid = 1'b0; r.outcome = OC_IDLE;
    end
    return r;
  endfunction

  // result side: random stalls, compare with the oldest expectation
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result outcome=%0d index=%0d", out_outcome, out_chosen_index);
      end else begin
        sched_res_t e;
        e = pending_results.pop_front();
        if (out_outcome !== e.outcome || out_chosen_index !== e.chosen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected outcome=%0d index=%0d, got %0d/%0d",
                     e.outcome, e.chosen, out_outcome, out_chosen_index);
        end
      end
    end
  end

  // one request; the expectation is queued at acceptance
  // valid is dropped by the next request's idling or by the caller
  task automatic send_request(input func_e fn, input logic [5:0] idx, input logic [2:0] st,
                              input logic [7:0] pr, input logic check_now,
                              input sched_res_t want);
    sched_res_t e;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= fn;
    in_entry_index  <= idx;
    in_new_status   <= st;
    in_new_priority <= pr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (fn == FN_WRITE) begin
      tbl_status[idx] = st; tbl_prio[idx] = pr; tbl_runs[idx] = '0;
    end else begin
      e = model_schedule();
      if (check_now && e !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row: model gives %0d/%0d, table says %0d/%0d",
                   e.outcome, e.chosen, want.outcome, want.chosen);
      end
      pending_results.push_back(want === 'x ? e : (check_now ? want : e));
    end
    @(negedge clk);
  endtask

  // stop sending, drain, let the block settle, then write one register
  task automatic write_reg(input logic [1:0] ri, input logic [15:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= ri; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (ri)
      CFG_MODE:      reg_mode      = val[0];
      CFG_QUANTUM:   reg_quantum   = val;
      CFG_AGING:     reg_aging     = val;
      CFG_PRIO_CEIL: reg_prio_ceil = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    logic [5:0] idx;
    logic [2:0] st;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 55) begin
        // mostly runnable entries among a small working set, sometimes anything
        idx = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(11));
        st  = ($urandom_range(1) == 0) ? ST_RUNNABLE : 3'($urandom);
        send_request(FN_WRITE, idx, st, 8'($urandom_range(9) == 0 ? $urandom : $urandom_range(8)),
                     1'b0, 'x);
      end else
        send_request(FN_SCHED, '0, '0, '0, 1'b0, 'x);
    end
  endtask

  row_t dir_rows[$];

  initial begin
    int n;
    mismatches = 0; idle_cycles = 0; no_idle = 1'b0;
    rst_n = 1'b0; in_valid = 1'b0; in_func = 1'b0; in_entry_index = '0;
    in_new_status = '0; in_new_priority = '0; out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_MODE; cfg_data = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      tbl_status[i] = ST_FREE; tbl_prio[i] = '0; tbl_runs[i] = '0;
    end
    cur_valid = 1'b0; cur_idx = '0; age_cnt = '0;
    reg_mode = 1'b0; reg_quantum = QUANTUM_RST; reg_aging = AGING_RST;
    reg_prio_ceil = PRIO_CEIL_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, round-robin mode from reset
    dir_rows = '{
      '{FN_SCHED, 6'd0,  3'd0,        8'd0,   1'b1, '{OC_NOLIVE, 6'd0}},
      '{FN_WRITE, 6'd63, ST_RUNNABLE, 8'd255, 1'b0, '0},
      '{FN_SCHED, 6'd0,  3'd0,        8'd0,   1'b1, '{OC_RUN, 6'd63}},
      '{FN_SCHED, 6'd0,  3'd0,        8'd0,   1'b1, '{OC_RUN, 6'd63}},
      '{FN_WRITE, 6'd0,  ST_RUNNABLE, 8'd0,   1'b0, '0},
      '{FN_SCHED, 6'd0,  3'd0,        8'd0,   1'b1, '{OC_RUN, 6'd0}},
      '{FN_SCHED, 6'd0,  3'd0,        8'd0,   1'b1, '{OC_RUN, 6'd63}},
      '{FN_WRITE, 6'd63, 3'd7,        8'd1,   1'b0, '0},
      '{FN_WRITE, 6'd0,  ST_DYING,    8'd2,   1'b0, '0},
      '{FN_SCHED, 6'd0,  3'd0,        8'd0,   1'b1, '{OC_IDLE, 6'd0}},
      '{FN_WRITE, 6'd0,  3'd4,        8'd0,   1'b0, '0},
      '{FN_WRITE, 6'd5,  3'd5,        8'd0,   1'b0, '0},
      '{FN_WRITE, 6'd6,  3'd6,        8'd0,   1'b0, '0},
      '{FN_SCHED, 6'd0,  3'd0,        8'd0,   1'b1, '{OC_NOLIVE, 6'd0}},
      '{FN_WRITE, 6'd10, ST_RUNNING,  8'd3,   1'b0, '0},
      '{FN_SCHED, 6'd0,  3'd0,        8'd0,   1'b0, '0}
    };
    foreach (dir_rows[i])
      send_request(dir_rows[i].fn, dir_rows[i].idx, dir_rows[i].st, dir_rows[i].pr,
                   dir_rows[i].check_now, dir_rows[i].want);

    // priority mode, quantum 0 (demote every pick above priority 1), boost every request
    write_reg(CFG_MODE, 16'd1);
    write_reg(CFG_QUANTUM, 16'd0);
    write_reg(CFG_AGING, 16'd1);
    write_reg(CFG_PRIO_CEIL, 16'd255);
    send_request(FN_WRITE, 6'd20, ST_RUNNABLE, 8'd255, 1'b0, 'x);
    send_request(FN_WRITE, 6'd21, ST_RUNNABLE, 8'd1, 1'b0, 'x);
    repeat (4) send_request(FN_SCHED, '0, '0, '0, 1'b0, 'x);

    // random phases over several register settings, one without idling
    random_phase(250);
    write_reg(CFG_AGING, 16'd65535);
    write_reg(CFG_QUANTUM, 16'd65535);
    write_reg(CFG_PRIO_CEIL, 16'd1);
    random_phase(250);
    // hold off the sender until everything is back
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    no_idle = 1'b1;
    write_reg(CFG_QUANTUM, 16'd3);
    write_reg(CFG_AGING, 16'd0);
    write_reg(CFG_PRIO_CEIL, 16'd7);
    random_phase(250);
    no_idle = 1'b0;
    write_reg(CFG_MODE, 16'd0);
    random_phase(250);
    write_reg(CFG_MODE, 16'd1);
    write_reg(CFG_AGING, 16'd5);
    n = RANDOM_REQS - 1000;
    random_phase(n);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: mlfq_round_robin_task_picker.f
+incdir+sv
sv/mlfq_pkg.sv
sv/mlfq_tbl.sv
sv/mlfq_alu.sv
sv/mlfq_round_robin_task_picker.sv
sv/mlfq_chk.sv
tb/mlfq_round_robin_task_picker_tb.sv
